// File: src/fqtok_pkg.sv
// Shared types and constants for the FASTA/FASTQ record tokenizer.
package fqtok_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  value;
        logic        read_has_n;
        logic [31:0] read_length;
        logic        qual_header_equal;
        logic [2:0]  error_code;
        logic        last;
    } out_item_t;

    localparam logic [2:0] EV_HDR_CHAR  = 3'd0;
    localparam logic [2:0] EV_BASE      = 3'd1;
    localparam logic [2:0] EV_QUAL_CHAR = 3'd2;
    localparam logic [2:0] EV_END_HDR   = 3'd3;
    localparam logic [2:0] EV_END_READ  = 3'd4;
    localparam logic [2:0] EV_END_QHDR  = 3'd5;
    localparam logic [2:0] EV_END_QUAL  = 3'd6;
    localparam logic [2:0] EV_ERROR     = 3'd7;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_FORMAT    = 3'd1;
    localparam logic [2:0] ERR_BASE      = 3'd2;
    localparam logic [2:0] ERR_QHDR      = 3'd3;
    localparam logic [2:0] ERR_HDR_LONG  = 3'd4;
    localparam logic [2:0] ERR_OPEN_LINE = 3'd5;

    localparam logic [1:0] FMT_NONE  = 2'd0;
    localparam logic [1:0] FMT_FASTA = 2'd1;
    localparam logic [1:0] FMT_FASTQ = 2'd2;
    localparam logic [1:0] FMT_DONE  = 2'd3;

    localparam logic [1:0] FA_HDR      = 2'd0;
    localparam logic [1:0] FA_HDR_EOL  = 2'd1;
    localparam logic [1:0] FA_READ     = 2'd2;
    localparam logic [1:0] FA_READ_EOL = 2'd3;

    localparam logic [1:0] ROLE_HDR  = 2'd0;
    localparam logic [1:0] ROLE_READ = 2'd1;
    localparam logic [1:0] ROLE_QHDR = 2'd2;
    localparam logic [1:0] ROLE_QUAL = 2'd3;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_AT = 8'h40;

    localparam logic [2:0] BASE_N   = 3'd4;
    localparam logic [2:0] BASE_BAD = 3'd5;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       eos;
        logic [2:0] code;
    } cls_item_t;

    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] r;
        begin
            unique case (c)
                8'h41:   r = 3'd0;
                8'h43:   r = 3'd1;
                8'h47:   r = 3'd2;
                8'h54:   r = 3'd3;
                8'h4E:   r = BASE_N;
                default: r = BASE_BAD;
            endcase
            return r;
        end
    endfunction

endpackage

// File: src/fqtok_front.sv
// Front part: takes raw bytes, classifies them and queues them for the back part.
module fqtok_front
    import fqtok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      q_valid,
    input  logic      q_ready,
    output cls_item_t q_data
);
    // Two-entry queue: full throughput with a registered ready.
    cls_item_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    cls_item_t  cls;
    logic       push, pop;

    always_comb
    begin
        cls.ch   = in_data.byte_value;
        cls.eol  = (in_data.byte_value == CH_LF) || (in_data.byte_value == CH_CR);
        cls.eos  = in_data.end_of_stream;
        cls.code = base_code(in_data.byte_value);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: src/fqtok_back.sv
// Back part: parsing state machine, header store and result output with skid buffer.
module fqtok_back
    import fqtok_pkg::*;
#(
    parameter int MAX_HEADER = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  cls_item_t q_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    localparam int AW = (MAX_HEADER > 1) ? $clog2(MAX_HEADER) : 1;
    localparam int LW = $clog2(MAX_HEADER + 2);
    localparam logic [LW-1:0] MAXH = LW'(MAX_HEADER);

    logic [1:0]    fmt_reg, fmt_next;
    logic [1:0]    fa_reg, fa_next;
    logic [1:0]    role_reg, role_next;
    logic          nonempty_reg, nonempty_next;
    logic          marker_reg, marker_next;
    logic          nseen_reg, nseen_next;
    logic [31:0]   bcount_reg, bcount_next;
    logic [LW-1:0] hlen_reg, hlen_next;
    logic [LW-1:0] cidx_reg, cidx_next;
    logic          cok_reg, cok_next;
    logic          err_reg, err_next;

    logic [7:0]    hstore [MAX_HEADER];
    logic          hwr;
    logic [AW-1:0] hwr_addr;
    // Header store read is done one item ahead: the compare index addresses it.
    logic [7:0]    hrd_reg;

    // Result buffer: two slots per item plus two skid slots.
    out_item_t     ob_reg [4];
    logic [1:0]    ob_wr_reg, ob_rd_reg;
    logic [2:0]    ob_cnt_reg;

    out_item_t     r0, r1;
    logic          e0, e1;
    logic          take;
    logic [1:0]    nres;

    function automatic out_item_t mk(input logic [2:0] k, input logic [7:0] v,
                                     input logic hn, input logic [31:0] len,
                                     input logic eq, input logic [2:0] ec);
        out_item_t r;
        begin
            r.event_kind        = k;
            r.value             = v;
            r.read_has_n        = hn;
            r.read_length       = len;
            r.qual_header_equal = eq;
            r.error_code        = ec;
            r.last              = 1'b0;
            return r;
        end
    endfunction

    // Room for two results guarantees an item never stalls mid-way.
    assign q_ready = (ob_cnt_reg <= 3'd2);
    assign take    = q_valid && q_ready;

    always_comb
    begin
        logic [7:0] c;
        logic       emit_base;
        logic       end_read;
        c             = q_data.ch;
        fmt_next      = fmt_reg;
        fa_next       = fa_reg;
        role_next     = role_reg;
        nonempty_next = nonempty_reg;
        marker_next   = marker_reg;
        nseen_next    = nseen_reg;
        bcount_next   = bcount_reg;
        hlen_next     = hlen_reg;
        cidx_next     = cidx_reg;
        cok_next      = cok_reg;
        err_next      = err_reg;
        hwr           = 1'b0;
        hwr_addr      = hlen_reg[AW-1:0];
        e0            = 1'b0;
        e1            = 1'b0;
        r0            = mk(EV_HDR_CHAR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
        r1            = r0;
        emit_base     = 1'b0;
        end_read      = 1'b0;

        if (!err_reg && fmt_reg != FMT_DONE)
        begin
            priority if (fmt_reg == FMT_NONE)
            begin
                if (c == CH_GT)
                begin
                    fmt_next = FMT_FASTA;
                    fa_next  = FA_HDR;
                end
                else if (c == CH_AT)
                begin
                    // The '@' opens the header line and is dropped as its marker.
                    fmt_next      = FMT_FASTQ;
                    nonempty_next = 1'b1;
                    hlen_next     = '0;
                    marker_next   = 1'b0;
                end
                else
                begin
                    e0       = 1'b1;
                    r0       = mk(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_FORMAT);
                    err_next = 1'b1;
                end
            end
            else if (fmt_reg == FMT_FASTA)
            begin
                unique case (fa_reg)
                    FA_HDR:
                    begin
                        e0 = 1'b1;
                        if (q_data.eol)
                        begin
                            fa_next = FA_HDR_EOL;
                            r0 = mk(EV_END_HDR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
                        end
                        else
                        begin
                            r0 = mk(EV_HDR_CHAR, c, 1'b0, 32'd0, 1'b0, ERR_NONE);
                        end
                    end
                    FA_HDR_EOL, FA_READ:
                    begin
                        if (q_data.eol)
                        begin
                            if (fa_reg == FA_READ)
                            begin
                                fa_next = FA_READ_EOL;
                            end
                        end
                        else
                        begin
                            fa_next   = FA_READ;
                            emit_base = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!q_data.eol)
                        begin
                            if (c == CH_GT)
                            begin
                                fa_next  = FA_HDR;
                                end_read = 1'b1;
                            end
                            else
                            begin
                                fa_next   = FA_READ;
                                emit_base = 1'b1;
                            end
                        end
                    end
                endcase
            end
            else
            begin
                if (q_data.eol)
                begin
                    if (nonempty_reg)
                    begin
                        unique case (role_reg)
                            ROLE_HDR:
                            begin
                                e0 = 1'b1;
                                r0 = mk(EV_END_HDR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
                            end
                            ROLE_READ:
                            begin
                                end_read = 1'b1;
                            end
                            ROLE_QHDR:
                            begin
                                e0 = 1'b1;
                                if (cidx_reg == '0)
                                begin
                                    r0 = mk(EV_END_QHDR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
                                end
                                else if (cok_reg && cidx_reg == hlen_reg)
                                begin
                                    r0 = mk(EV_END_QHDR, 8'd0, 1'b0, 32'd0, 1'b1, ERR_NONE);
                                end
                                else
                                begin
                                    r0 = mk(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_QHDR);
                                    err_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                e0 = 1'b1;
                                r0 = mk(EV_END_QUAL, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
                            end
                        endcase
                        if (!err_next)
                        begin
                            role_next     = role_reg + 2'd1;
                            nonempty_next = 1'b0;
                            marker_next   = 1'b1;
                        end
                    end
                end
                else
                begin
                    logic [LW-1:0] ci;
                    logic          ok;
                    ci = cidx_reg;
                    ok = cok_reg;
                    nonempty_next = 1'b1;
                    if (!nonempty_reg && role_reg == ROLE_HDR)
                    begin
                        hlen_next = '0;
                    end
                    if (!nonempty_reg && role_reg == ROLE_QHDR)
                    begin
                        ci = '0;
                        ok = 1'b1;
                    end
                    cidx_next = ci;
                    cok_next  = ok;
                    if ((role_reg == ROLE_HDR || role_reg == ROLE_QHDR) && marker_reg)
                    begin
                        marker_next = 1'b0;
                    end
                    else
                    begin
                        unique case (role_reg)
                            ROLE_HDR:
                            begin
                                e0 = 1'b1;
                                if (hlen_reg >= MAXH)
                                begin
                                    r0 = mk(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0,
                                            ERR_HDR_LONG);
                                    err_next = 1'b1;
                                end
                                else
                                begin
                                    r0 = mk(EV_HDR_CHAR, c, 1'b0, 32'd0, 1'b0, ERR_NONE);
                                    hwr       = 1'b1;
                                    hlen_next = hlen_reg + LW'(1);
                                end
                            end
                            ROLE_READ:
                            begin
                                emit_base = 1'b1;
                            end
                            ROLE_QHDR:
                            begin
                                if (ci >= hlen_reg || hrd_reg != c)
                                begin
                                    cok_next = 1'b0;
                                end
                                if (ci <= MAXH)
                                begin
                                    cidx_next = ci + LW'(1);
                                end
                            end
                            default:
                            begin
                                e0 = 1'b1;
                                r0 = mk(EV_QUAL_CHAR, c, 1'b0, 32'd0, 1'b0, ERR_NONE);
                            end
                        endcase
                    end
                end
            end

            if (emit_base)
            begin
                e0 = 1'b1;
                if (q_data.code == BASE_BAD)
                begin
                    r0 = mk(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_BASE);
                    err_next = 1'b1;
                end
                else
                begin
                    r0 = mk(EV_BASE, {5'd0, q_data.code}, 1'b0, 32'd0, 1'b0, ERR_NONE);
                    if (q_data.code == BASE_N)
                    begin
                        nseen_next = 1'b1;
                    end
                    if (bcount_reg != 32'hFFFF_FFFF)
                    begin
                        bcount_next = bcount_reg + 32'd1;
                    end
                end
            end
            if (end_read)
            begin
                e0 = 1'b1;
                r0 = mk(EV_END_READ, 8'd0, nseen_reg, bcount_reg, 1'b0, ERR_NONE);
                nseen_next  = 1'b0;
                bcount_next = 32'd0;
            end

            // End of stream closes the file after the byte itself.
            if (q_data.eos && !err_next)
            begin
                if (fmt_next == FMT_FASTA)
                begin
                    if (fa_next == FA_HDR)
                    begin
                        r1 = mk(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_OPEN_LINE);
                        e1 = 1'b1;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        r1 = mk(EV_END_READ, 8'd0, nseen_next, bcount_next, 1'b0,
                                ERR_NONE);
                        e1 = 1'b1;
                        nseen_next  = 1'b0;
                        bcount_next = 32'd0;
                    end
                end
                else if (fmt_next == FMT_FASTQ && nonempty_next)
                begin
                    r1 = mk(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_OPEN_LINE);
                    e1 = 1'b1;
                    err_next = 1'b1;
                end
                if (!err_next)
                begin
                    fmt_next = FMT_DONE;
                end
            end
        end

        if (e1)
        begin
            r1.last = 1'b1;
            if (!e0)
            begin
                r0 = r1;
                e0 = 1'b1;
                e1 = 1'b0;
            end
        end
        else
        begin
            r0.last = 1'b1;
        end
    end

    assign nres = {1'b0, take && e0} + {1'b0, take && e1};

    always_ff @(posedge clk)
    begin
        if (take && hwr)
        begin
            hstore[hwr_addr] <= q_data.ch;
        end
        hrd_reg <= hstore[take ? cidx_next[AW-1:0] : cidx_reg[AW-1:0]];
    end

    // The read of the stored byte uses next compare index; a write into the
    // same slot never coincides since writes happen only on header lines.
    always_ff @(posedge clk)
    begin
        if (take && e0)
        begin
            ob_reg[ob_wr_reg] <= r0;
        end
        if (take && e1)
        begin
            ob_reg[ob_wr_reg + 2'd1] <= r1;
        end
    end

    assign out_valid = (ob_cnt_reg != 3'd0);
    assign out_data  = ob_reg[ob_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_NONE;
            fa_reg       <= FA_HDR;
            role_reg     <= ROLE_HDR;
            nonempty_reg <= 1'b0;
            marker_reg   <= 1'b1;
            nseen_reg    <= 1'b0;
            bcount_reg   <= 32'd0;
            hlen_reg     <= '0;
            cidx_reg     <= '0;
            cok_reg      <= 1'b1;
            err_reg      <= 1'b0;
            ob_wr_reg    <= 2'd0;
            ob_rd_reg    <= 2'd0;
            ob_cnt_reg   <= 3'd0;
        end
        else
        begin
            logic pop;
            pop = out_valid && out_ready;
            if (take)
            begin
                fmt_reg      <= fmt_next;
                fa_reg       <= fa_next;
                role_reg     <= role_next;
                nonempty_reg <= nonempty_next;
                marker_reg   <= marker_next;
                nseen_reg    <= nseen_next;
                bcount_reg   <= bcount_next;
                hlen_reg     <= hlen_next;
                cidx_reg     <= cidx_next;
                cok_reg      <= cok_next;
                err_reg      <= err_next;
            end
            ob_wr_reg  <= ob_wr_reg + nres;
            if (pop)
            begin
                ob_rd_reg <= ob_rd_reg + 2'd1;
            end
            ob_cnt_reg <= ob_cnt_reg + {1'b0, nres} - {2'b0, pop};
        end
    end
endmodule

// File: src/fasta_fastq_record_tokenizer.sv
// Top level of the FASTA/FASTQ record tokenizer.
//
// Input channel in_valid/in_ready/in_data carries one file byte per item with
// an end-of-stream flag. Output channel out_valid/out_ready/out_data carries
// result items: header, base and quality characters, end-of-field events and
// errors; the last item caused by one byte has last set.
// A byte is taken every cycle when the output keeps up. A byte passes the
// two-entry classify queue and the parser; the queue entry is registered, and
// the parser registers its results in the result buffer. A byte giving two
// results (end of stream) occupies two slots of the four-slot result buffer.
// When the receiver stalls, results collect in the result buffer; the parser
// holds once fewer than two slots are free, and the queue then fills and
// drops in_ready.
// Reset clears the parser to expect the format marker; the header store is
// not cleared. Errors are sticky until reset, and after the end of stream
// bytes are taken but ignored.
module fasta_fastq_record_tokenizer
    import fqtok_pkg::*;
#(
    parameter int MAX_HEADER = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    logic      q_valid;
    logic      q_ready;
    cls_item_t q_data;

    fqtok_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    fqtok_back #(.MAX_HEADER(MAX_HEADER)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the FASTA/FASTQ record tokenizer.
`timescale 1ns / 1ps

module tb
    import fqtok_pkg::*;
();

    localparam int HDR_MAX     = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        logic [2:0] kind;
        logic [7:0] val;
    } drow_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    fasta_fastq_record_tokenizer #(.MAX_HEADER(HDR_MAX)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Tokenizer state as the testbench sees it.
    logic [1:0]  fmt;
    logic [1:0]  fa_phase;
    logic [1:0]  line_role;
    logic        line_open;
    logic        marker_due;
    logic        saw_n;
    logic [31:0] base_total;
    logic [7:0]  hdr_mem [HDR_MAX];
    logic [15:0] hdr_len;
    logic [15:0] cmp_idx;
    logic        cmp_ok;
    logic        stuck;

    out_item_t byte_events[$];
    out_item_t expected_events[$];
    in_item_t  byte_stream[$];
    drow_t     dir_rows[$];
    int        errors;
    int        cycles;
    int        stall_left;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    function automatic void add_event(logic [2:0] k, logic [7:0] v, logic hn,
                                      logic [31:0] len, logic eq, logic [2:0] ec);
        out_item_t r;
        r = '{k, v, hn, len, eq, ec, 1'b0};
        byte_events = {byte_events, r};
    endfunction

    function automatic void raise(logic [2:0] ec);
        stuck = 1'b1;
        add_event(EV_ERROR, 8'd0, 1'b0, 32'd0, 1'b0, ec);
    endfunction

    function automatic void take_base(logic [7:0] c);
        logic [2:0] code;
        case (c)
            "A":     code = 3'd0;
            "C":     code = 3'd1;
            "G":     code = 3'd2;
            "T":     code = 3'd3;
            "N":     code = 3'd4;
            default: code = 3'd5;
        endcase
        if (code > 3'd4)
        begin
            raise(ERR_BASE);
            return;
        end
        if (code == 3'd4)
            saw_n = 1'b1;
        if (base_total != 32'hFFFF_FFFF)
            base_total++;
        add_event(EV_BASE, {5'd0, code}, 1'b0, 32'd0, 1'b0, ERR_NONE);
    endfunction

    function automatic void close_read();
        add_event(EV_END_READ, 8'd0, saw_n, base_total, 1'b0, ERR_NONE);
        saw_n = 1'b0;
        base_total = 32'd0;
    endfunction

    function automatic void fasta_char(logic [7:0] c, logic eol);
        case (fa_phase)
            FA_HDR:
                if (eol)
                begin
                    fa_phase = FA_HDR_EOL;
                    add_event(EV_END_HDR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
                end
                else
                    add_event(EV_HDR_CHAR, c, 1'b0, 32'd0, 1'b0, ERR_NONE);
            FA_HDR_EOL:
                if (!eol)
                begin
                    fa_phase = FA_READ;
                    take_base(c);
                end
            FA_READ:
                if (eol)
                    fa_phase = FA_READ_EOL;
                else
                    take_base(c);
            default:
                if (!eol)
                begin
                    if (c == CH_GT)
                    begin
                        fa_phase = FA_HDR;
                        close_read();
                    end
                    else
                    begin
                        fa_phase = FA_READ;
                        take_base(c);
                    end
                end
        endcase
    endfunction

    function automatic void fastq_line_end();
        case (line_role)
            ROLE_HDR:
                add_event(EV_END_HDR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
            ROLE_READ:
                close_read();
            ROLE_QHDR:
                if (cmp_idx == 16'd0)
                    add_event(EV_END_QHDR, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
                else if (cmp_ok && cmp_idx == hdr_len)
                    add_event(EV_END_QHDR, 8'd0, 1'b0, 32'd0, 1'b1, ERR_NONE);
                else
                begin
                    raise(ERR_QHDR);
                    return;
                end
            default:
                add_event(EV_END_QUAL, 8'd0, 1'b0, 32'd0, 1'b0, ERR_NONE);
        endcase
        line_role = line_role + 2'd1;
        line_open = 1'b0;
        marker_due = 1'b1;
    endfunction

    function automatic void fastq_char(logic [7:0] c, logic eol);
        if (eol)
        begin
            if (line_open)
                fastq_line_end();
            return;
        end
        if (!line_open)
        begin
            line_open = 1'b1;
            if (line_role == ROLE_HDR)
                hdr_len = 16'd0;
            if (line_role == ROLE_QHDR)
            begin
                cmp_idx = 16'd0;
                cmp_ok = 1'b1;
            end
        end
        if ((line_role == ROLE_HDR || line_role == ROLE_QHDR) && marker_due)
        begin
            marker_due = 1'b0;
            return;
        end
        case (line_role)
            ROLE_HDR:
                if (hdr_len >= HDR_MAX)
                    raise(ERR_HDR_LONG);
                else
                begin
                    hdr_mem[hdr_len] = c;
                    hdr_len++;
                    add_event(EV_HDR_CHAR, c, 1'b0, 32'd0, 1'b0, ERR_NONE);
                end
            ROLE_READ:
                take_base(c);
            ROLE_QHDR:
            begin
                if (cmp_idx >= hdr_len)
                    cmp_ok = 1'b0;
                else if (hdr_mem[cmp_idx] != c)
                    cmp_ok = 1'b0;
                if (cmp_idx <= HDR_MAX)
                    cmp_idx++;
            end
            default:
                add_event(EV_QUAL_CHAR, c, 1'b0, 32'd0, 1'b0, ERR_NONE);
        endcase
    endfunction

    // Works out the events for one accepted byte into byte_events.
    function automatic void tokenize_byte(in_item_t it);
        logic [7:0] c;
        logic       eol;
        c = it.byte_value;
        eol = (c == CH_LF) || (c == CH_CR);
        byte_events.delete();
        if (stuck || fmt == FMT_DONE)
            return;
        if (fmt == FMT_NONE)
        begin
            if (c == CH_GT)
            begin
                fmt = FMT_FASTA;
                fa_phase = FA_HDR;
            end
            else if (c == CH_AT)
            begin
                fmt = FMT_FASTQ;
                fastq_char(c, 1'b0);
            end
            else
                raise(ERR_FORMAT);
        end
        else if (fmt == FMT_FASTA)
            fasta_char(c, eol);
        else
            fastq_char(c, eol);
        if (it.end_of_stream && !stuck)
        begin
            if (fmt == FMT_FASTA)
            begin
                if (fa_phase == FA_HDR)
                    raise(ERR_OPEN_LINE);
                else
                    close_read();
            end
            else if (fmt == FMT_FASTQ && line_open)
                raise(ERR_OPEN_LINE);
            if (!stuck)
                fmt = FMT_DONE;
        end
        if (byte_events.size() > 0)
            byte_events[byte_events.size() - 1].last = 1'b1;
    endfunction

    function automatic void put(logic [7:0] c, logic eos = 1'b0);
        in_item_t it;
        it.byte_value = c;
        it.end_of_stream = eos;
        byte_stream = {byte_stream, it};
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] base_char();
        logic [7:0] pick [5] = '{"A", "C", "G", "T", "N"};
        return pick[$urandom_range(4)];
    endfunction

    function automatic void line_break();
        case ($urandom_range(5))
            0:       put(CH_CR);
            1:       begin put(CH_CR); put(CH_LF); end
            2:       begin put(CH_LF); put(CH_LF); end
            default: put(CH_LF);
        endcase
    endfunction

    function automatic int short_len(int lo);
        if ($urandom_range(15) == 0)
            return lo + $urandom_range(30);
        return lo + $urandom_range(8);
    endfunction

    function automatic void fasta_bases(int n);
        for (int i = 0; i < n; i++)
        begin
            put(base_char());
            if ($urandom_range(5) == 0)
                line_break();
        end
    endfunction

    function automatic void add_row(logic [7:0] c, logic typed = 1'b0,
                                    logic [2:0] k = EV_HDR_CHAR, logic [7:0] v = 8'd0);
        drow_t r;
        r = '{c, 1'b0, typed, k, v};
        dir_rows = {dir_rows, r};
    endfunction

    // Builds the random part: one file, since only reset revives the block.
    function automatic void build_stream(logic fq_file);
        logic [7:0] hdr [$];
        int         ending;
        int         n;
        ending = $urandom_range(4);
        while (byte_stream.size() < 520)
        begin
            if (!fq_file)
            begin
                put(CH_GT);
                n = short_len(0);
                for (int i = 0; i < n; i++)
                    put(text_char());
                line_break();
                fasta_bases(short_len(1));
            end
            else
            begin
                hdr.delete();
                n = ($urandom_range(39) == 0) ? HDR_MAX : short_len(0);
                for (int i = 0; i < n; i++)
                    hdr = {hdr, text_char()};
                put(CH_AT);
                foreach (hdr[i])
                    put(hdr[i]);
                line_break();
                for (int i = short_len(1); i > 0; i--)
                    put(base_char());
                line_break();
                put("+");
                if ($urandom_range(1) == 0)
                    foreach (hdr[i])
                        put(hdr[i]);
                line_break();
                for (int i = short_len(1); i > 0; i--)
                    put(text_char());
                line_break();
            end
        end
        // Close the file in one of several ways, good or broken.
        case (ending)
            0:
                byte_stream[byte_stream.size() - 1].end_of_stream = 1'b1;
            1:
            begin
                put("a");
                put(CH_LF, 1'b1);
            end
            2:
                if (fq_file)
                begin
                    put(CH_AT); put("q"); put(CH_LF); put("A"); put(CH_LF);
                    put("+"); put("z"); put(CH_LF, 1'b1);
                end
                else
                    put(CH_GT, 1'b1);
            3:
                if (fq_file)
                begin
                    put(CH_AT);
                    for (int i = 0; i <= HDR_MAX; i++)
                        put(text_char());
                    put(CH_LF, 1'b1);
                end
                else
                begin
                    put(CH_GT); put("h", 1'b1);
                end
            default:
            begin
                put(fq_file ? CH_AT : CH_GT);
                put("x", 1'b1);
            end
        endcase
        for (int i = 0; i < 8; i++)
            put(8'($urandom), 1'($urandom));
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(in_item_t it, logic typed, logic [2:0] k, logic [7:0] v);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tokenize_byte(it);
        if (typed)
        begin
            if (byte_events.size() == 0)
                report("typed event missing", 32'd0, {29'd0, k});
            else
            begin
                if (byte_events[0].event_kind != k)
                    report("typed kind", 32'(byte_events[0].event_kind), 32'(k));
                if (byte_events[0].value != v)
                    report("typed value", 32'(byte_events[0].value), 32'(v));
            end
        end
        expected_events = {expected_events, byte_events};
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fasta_fastq_record_tokenizer: mismatch");
            $finish;
        end
    end

    // Result side: checks accepted items and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                    report("unexpected item", 32'(out_data.event_kind), 32'd0);
                else
                begin
                    out_item_t want;
                    want = expected_events.pop_front();
                    if (out_data.event_kind != want.event_kind)
                        report("event_kind", 32'(out_data.event_kind),
                               32'(want.event_kind));
                    if (out_data.value != want.value)
                        report("value", 32'(out_data.value), 32'(want.value));
                    if (out_data.read_has_n != want.read_has_n)
                        report("read_has_n", 32'(out_data.read_has_n),
                               32'(want.read_has_n));
                    if (out_data.read_length != want.read_length)
                        report("read_length", out_data.read_length, want.read_length);
                    if (out_data.qual_header_equal != want.qual_header_equal)
                        report("qual_header_equal", 32'(out_data.qual_header_equal),
                               32'(want.qual_header_equal));
                    if (out_data.error_code != want.error_code)
                        report("error_code", 32'(out_data.error_code),
                               32'(want.error_code));
                    if (out_data.last != want.last)
                        report("last", 32'(out_data.last), 32'(want.last));
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(9) < 7)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 50)
                                                       : $urandom_range(0, 2);
            end
        end
    end

    initial
    begin
        int         mode;
        logic       fq_file;
        logic [7:0] junk;
        in_item_t   it;
        errors = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        fmt = FMT_NONE;
        fa_phase = FA_HDR;
        line_role = ROLE_HDR;
        line_open = 1'b0;
        marker_due = 1'b1;
        saw_n = 1'b0;
        base_total = 32'd0;
        hdr_len = 16'd0;
        cmp_idx = 16'd0;
        cmp_ok = 1'b1;
        stuck = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One file per run; the seed picks FASTQ, FASTA or a bad first byte.
        mode = $urandom_range(15);
        fq_file = (mode < 8);
        if (mode == 15)
        begin
            do
                junk = 8'($urandom);
            while (junk == CH_GT || junk == CH_AT);
            add_row(junk, 1'b1, EV_ERROR, 8'd0);
            for (int i = 0; i < 549; i++)
                put(8'($urandom), 1'($urandom));
        end
        else if (fq_file)
        begin
            add_row(CH_AT);
            add_row("r", 1'b1, EV_HDR_CHAR, "r");
            add_row(8'hFF, 1'b1, EV_HDR_CHAR, 8'hFF);
            add_row(8'h00, 1'b1, EV_HDR_CHAR, 8'h00);
            add_row(CH_LF, 1'b1, EV_END_HDR, 8'd0);
            add_row(CH_LF);
            add_row("A", 1'b1, EV_BASE, 8'd0);
            add_row("C", 1'b1, EV_BASE, 8'd1);
            add_row("G", 1'b1, EV_BASE, 8'd2);
            add_row("T", 1'b1, EV_BASE, 8'd3);
            add_row("N", 1'b1, EV_BASE, 8'd4);
            add_row(CH_CR);
            add_row("+");
            add_row(CH_LF, 1'b1, EV_END_QHDR, 8'd0);
            add_row("!", 1'b1, EV_QUAL_CHAR, "!");
            add_row(8'hFE, 1'b1, EV_QUAL_CHAR, 8'hFE);
            add_row(CH_LF, 1'b1, EV_END_QUAL, 8'd0);
            add_row(CH_AT);
            add_row("x");
            add_row(CH_LF);
            add_row("A");
            add_row(CH_LF);
            add_row("+");
            add_row("x");
            add_row(CH_LF);
            add_row("#");
            add_row(CH_LF);
            build_stream(1'b1);
        end
        else
        begin
            add_row(CH_GT);
            add_row(8'hFF, 1'b1, EV_HDR_CHAR, 8'hFF);
            add_row(CH_GT, 1'b1, EV_HDR_CHAR, CH_GT);
            add_row(CH_CR, 1'b1, EV_END_HDR, 8'd0);
            add_row(CH_LF);
            add_row("A", 1'b1, EV_BASE, 8'd0);
            add_row("C", 1'b1, EV_BASE, 8'd1);
            add_row(CH_LF);
            add_row("G", 1'b1, EV_BASE, 8'd2);
            add_row("T", 1'b1, EV_BASE, 8'd3);
            add_row("N", 1'b1, EV_BASE, 8'd4);
            add_row(CH_CR);
            add_row(CH_LF);
            add_row(CH_GT, 1'b1, EV_END_READ, 8'd0);
            add_row("h");
            add_row(CH_LF);
            fasta_bases(3);
            build_stream(1'b0);
        end

        foreach (dir_rows[i])
        begin
            it.byte_value = dir_rows[i].ch;
            it.end_of_stream = dir_rows[i].eos;
            send(it, dir_rows[i].typed, dir_rows[i].kind, dir_rows[i].val);
        end
        foreach (byte_stream[i])
            send(byte_stream[i], 1'b0, EV_HDR_CHAR, 8'd0);
        in_valid <= 1'b0;

        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("fasta_fastq_record_tokenizer: match");
        else
            $display("fasta_fastq_record_tokenizer: mismatch");
        $finish;
    end

endmodule
